// File: design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// File: design/bmf_pkg.sv
`timescale 1ns / 1ps
package bmf_pkg;
    localparam logic [1:0] KIND_TRAIN = 2'd0;
    localparam logic [1:0] KIND_EVAL  = 2'd1;
    localparam logic [1:0] KIND_WR_U  = 2'd2;
    localparam logic [1:0] KIND_WR_I  = 2'd3;

    localparam logic [2:0] REG_LR   = 3'd0;
    localparam logic [2:0] REG_RW   = 3'd1;
    localparam logic [2:0] REG_MEAN = 3'd2;
    localparam logic [2:0] REG_MIN  = 3'd3;
    localparam logic [2:0] REG_MAX  = 3'd4;
    localparam logic [2:0] REG_BO   = 3'd5;

    typedef struct packed {
        logic [1:0]         kind;
        logic [9:0]         user_id;
        logic [9:0]         item_id;
        logic signed [31:0] rating;
        logic [3:0]         factor_index;
        logic signed [31:0] factor_value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] prediction;
        logic signed [31:0] error;
    } out_word_t;

    typedef struct packed {
        logic [16:0]        learn_rate;
        logic [16:0]        reg_weight;
        logic signed [31:0] global_mean;
        logic signed [31:0] min_score;
        logic signed [31:0] max_score;
        logic               bias_only;
    } cfg_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage

// File: design/bmf_ram.sv
`timescale 1ns / 1ps
module bmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

// File: design/bmf_fmul.sv
`timescale 1ns / 1ps
// registered fixed-point multiply: floor shift, then saturated and full-width outputs
module bmf_fmul #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [31:0] p,
    output logic signed [65:0] ps
);
    logic signed [65:0] prod;
    always_comb prod = a * b;
    always_ff @(posedge clk)
    begin
        p <= bmf_pkg::sat32(prod >>> FRAC_BITS);
        // dot product terms are summed without saturation
        ps <= prod >>> FRAC_BITS;
    end
endmodule

// File: design/biased_mf_sgd_update_top.sv
`timescale 1ns / 1ps
// channel | dir | word
// in      | in  | bmf_pkg::in_word_t   (in_valid/in_ready)
// out     | out | bmf_pkg::out_word_t  (out_valid/out_ready)
// cfg     | in  | cfg_index, cfg_data  (cfg_valid/cfg_ready)
// Sequential: one item at a time through a single shared multiplier.
// Each item passes S_RDB and S_PRED; a dot term steps S_DOTRD, S_DOTMUL, S_DOTACC,
// and a factor update S_F_RD to S_F_WR. Writes and out-of-range ids skip both, and
// bias-only training does too. Memory reads and products are registered.
// Bias memories are cleared after reset, over max(NUM_USERS,NUM_ITEMS) addresses.
// in_ready drops while busy and while a result waits; out holds until out_ready.
module biased_mf_sgd_update_top #(
    parameter int NUM_USERS = 1024,
    parameter int NUM_ITEMS = 1024,
    parameter int FACTORS   = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bmf_pkg::in_word_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bmf_pkg::out_word_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int IW = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    localparam int FW = (FACTORS > 1) ? $clog2(FACTORS) : 1;
    localparam int UD = NUM_USERS * FACTORS;
    localparam int ID = NUM_ITEMS * FACTORS;
    localparam int UFW = (UD > 1) ? $clog2(UD) : 1;
    localparam int IFW = (ID > 1) ? $clog2(ID) : 1;
    localparam int CLR = (NUM_USERS > NUM_ITEMS) ? NUM_USERS : NUM_ITEMS;
    localparam int CW = $clog2(CLR + 1);

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_RDB, S_DOTRD, S_DOTMUL, S_DOTACC, S_PRED,
        S_UB1, S_UB2, S_UB3, S_IB1, S_IB2,
        S_F_RD, S_F_EQ, S_F_EP, S_F_RP, S_F_RQ, S_F_G1, S_F_G2,
        S_F_WR, S_OUT
    } state_t;

    state_t state_reg;
    bmf_pkg::cfg_t cfg_reg;
    bmf_pkg::in_word_t item_reg;
    logic [CW-1:0] clr_reg;
    logic [FW:0] k_reg;
    logic signed [65:0] acc_reg;
    logic signed [31:0] err_reg, t1_reg, t2_reg, p_reg, q_reg;
    logic signed [31:0] np_reg;
    logic out_valid_reg;
    bmf_pkg::out_word_t out_reg;

    // memories
    logic ub_we, ib_we, uf_we, if_we;
    logic [UW-1:0] ub_a;
    logic [IW-1:0] ib_a;
    logic [UFW-1:0] uf_a;
    logic [IFW-1:0] if_a;
    logic [31:0] ub_wd, ib_wd, uf_wd, if_wd, ub_rd, ib_rd, uf_rd, if_rd;

    bmf_ram #(.WIDTH(32), .DEPTH(NUM_USERS)) u_ub (.clk, .we(ub_we), .waddr(ub_a),
        .wdata(ub_wd), .raddr(ub_a), .rdata(ub_rd));
    bmf_ram #(.WIDTH(32), .DEPTH(NUM_ITEMS)) u_ib (.clk, .we(ib_we), .waddr(ib_a),
        .wdata(ib_wd), .raddr(ib_a), .rdata(ib_rd));
    bmf_ram #(.WIDTH(32), .DEPTH(UD)) u_uf (.clk, .we(uf_we), .waddr(uf_a),
        .wdata(uf_wd), .raddr(uf_a), .rdata(uf_rd));
    bmf_ram #(.WIDTH(32), .DEPTH(ID)) u_if (.clk, .we(if_we), .waddr(if_a),
        .wdata(if_wd), .raddr(if_a), .rdata(if_rd));

    logic signed [32:0] ma, mb;
    logic signed [31:0] mp;
    logic signed [65:0] mps;
    bmf_fmul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk, .a(ma), .b(mb), .p(mp), .ps(mps));

    logic uid_ok, iid_ok, fidx_ok;
    logic [FW-1:0] kk;
    logic [FW-1:0] fi;
    logic signed [65:0] tot;
    logic signed [31:0] pc;

    always_comb
    begin
        uid_ok = 32'(item_reg.user_id) < NUM_USERS;
        iid_ok = 32'(item_reg.item_id) < NUM_ITEMS;
        fidx_ok = 32'(item_reg.factor_index) < FACTORS;
        kk = k_reg[FW-1:0];
        fi = FW'(item_reg.factor_index);
        ub_a = (state_reg == S_CLEAR) ? UW'(clr_reg) : UW'(item_reg.user_id);
        ib_a = (state_reg == S_CLEAR) ? IW'(clr_reg) : IW'(item_reg.item_id);
        ub_we = 1'b0; ib_we = 1'b0; uf_we = 1'b0; if_we = 1'b0;
        ub_wd = 32'd0; ib_wd = 32'd0;
        uf_wd = p_reg; if_wd = q_reg;
        uf_a = UFW'(32'(item_reg.user_id) * FACTORS + 32'(kk));
        if_a = IFW'(32'(item_reg.item_id) * FACTORS + 32'(kk));
        ma = 33'sd0; mb = 33'sd0;
        case (state_reg)
            S_CLEAR:
            begin
                ub_we = 32'(clr_reg) < NUM_USERS;
                ib_we = 32'(clr_reg) < NUM_ITEMS;
            end
            S_IDLE:
            begin
                uf_a = UFW'(32'(item_reg.user_id) * FACTORS + 32'(fi));
                if_a = IFW'(32'(item_reg.item_id) * FACTORS + 32'(fi));
            end
            S_DOTMUL:
            begin
                ma = 33'(signed'(uf_rd));
                mb = 33'(signed'(if_rd));
            end
            // bias steps: both reg terms, then both learn-rate terms
            S_UB1:
            begin
                ma = {16'd0, cfg_reg.reg_weight};
                mb = 33'(signed'(ub_rd));
            end
            S_UB2:
            begin
                ma = {16'd0, cfg_reg.reg_weight};
                mb = 33'(signed'(ib_rd));
            end
            S_UB3:
            begin
                ma = {16'd0, cfg_reg.learn_rate};
                mb = 33'(t1_reg);
            end
            S_IB1:
            begin
                ma = {16'd0, cfg_reg.learn_rate};
                mb = 33'(t2_reg);
                ub_we = 1'b1;
                ub_wd = bmf_pkg::sat32(66'(signed'(ub_rd)) + 66'(mp));
            end
            S_IB2:
            begin
                ib_we = 1'b1;
                ib_wd = bmf_pkg::sat32(66'(signed'(ib_rd)) + 66'(mp));
            end
            S_F_EQ:
            begin
                ma = 33'(err_reg);
                mb = 33'(signed'(if_rd));
            end
            S_F_EP:
            begin
                ma = 33'(err_reg);
                mb = 33'(p_reg);
            end
            S_F_RP:
            begin
                ma = {16'd0, cfg_reg.reg_weight};
                mb = 33'(p_reg);
            end
            S_F_RQ:
            begin
                ma = {16'd0, cfg_reg.reg_weight};
                mb = 33'(q_reg);
            end
            S_F_G1:
            begin
                ma = {16'd0, cfg_reg.learn_rate};
                mb = 33'(t1_reg);
            end
            S_F_G2:
            begin
                ma = {16'd0, cfg_reg.learn_rate};
                mb = 33'(t2_reg);
            end
            S_F_WR:
            begin
                uf_we = 1'b1; if_we = 1'b1;
                uf_wd = np_reg; if_wd = bmf_pkg::sat32(66'(q_reg) + 66'(mp));
            end
            S_PRED:
            begin
                if (item_reg.kind == bmf_pkg::KIND_WR_U)
                begin
                    uf_a = UFW'(32'(item_reg.user_id) * FACTORS + 32'(fi));
                    uf_wd = item_reg.factor_value;
                    uf_we = uid_ok && fidx_ok;
                end
                if (item_reg.kind == bmf_pkg::KIND_WR_I)
                begin
                    if_a = IFW'(32'(item_reg.item_id) * FACTORS + 32'(fi));
                    if_wd = item_reg.factor_value;
                    if_we = iid_ok && fidx_ok;
                end
            end
            default: ;
        endcase
        tot = acc_reg;
        pc = bmf_pkg::sat32(tot);
    end

    logic signed [31:0] cl;
    always_comb
    begin
        cl = pc;
        if (cl > cfg_reg.max_score) cl = cfg_reg.max_score;
        if (cl < cfg_reg.min_score) cl = cfg_reg.min_score;
    end

    logic do_train, use_dot;
    always_comb
    begin
        do_train = item_reg.kind == bmf_pkg::KIND_TRAIN;
        use_dot = !do_train || !cfg_reg.bias_only;
    end

    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            cfg_reg <= '{17'd655, 17'd655, 32'sd0, 32'sd0, 32'sd327680, 1'b0};
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    bmf_pkg::REG_LR:   cfg_reg.learn_rate <= cfg_data[16:0];
                    bmf_pkg::REG_RW:   cfg_reg.reg_weight <= cfg_data[16:0];
                    bmf_pkg::REG_MEAN: cfg_reg.global_mean <= cfg_data;
                    bmf_pkg::REG_MIN:  cfg_reg.min_score <= cfg_data;
                    bmf_pkg::REG_MAX:  cfg_reg.max_score <= cfg_data;
                    bmf_pkg::REG_BO:   cfg_reg.bias_only <= cfg_data[0];
                    default: ;
                endcase
            end
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == CLR - 1) state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        state_reg <= S_RDB;
                    end
                S_RDB:
                begin
                    // bias read issued; factor address k=0
                    k_reg <= '0;
                    if (item_reg.kind == bmf_pkg::KIND_WR_U ||
                        item_reg.kind == bmf_pkg::KIND_WR_I || !uid_ok || !iid_ok)
                    begin
                        err_reg <= 32'sd0;
                        state_reg <= S_PRED;
                    end
                    else
                        state_reg <= S_DOTRD;
                end
                S_DOTRD:
                begin
                    // biases seed the sum on the first term only
                    if (k_reg == '0)
                        acc_reg <= 66'(cfg_reg.global_mean) + 66'(signed'(ub_rd))
                            + 66'(signed'(ib_rd));
                    state_reg <= use_dot ? S_DOTMUL : S_PRED;
                end
                S_DOTMUL: state_reg <= S_DOTACC;
                S_DOTACC:
                begin
                    acc_reg <= acc_reg + mps;
                    if (32'(k_reg) == FACTORS - 1)
                    begin
                        k_reg <= '0;
                        state_reg <= S_PRED;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_DOTRD;
                    end
                end
                S_PRED:
                begin
                    if (item_reg.kind == bmf_pkg::KIND_WR_U ||
                        item_reg.kind == bmf_pkg::KIND_WR_I || !uid_ok || !iid_ok)
                    begin
                        out_reg <= '{32'sd0, 32'sd0};
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        err_reg <= bmf_pkg::sat32(66'(item_reg.rating)
                            - 66'(do_train ? cl : pc));
                        out_reg <= '{do_train ? cl : pc, bmf_pkg::sat32(
                            66'(item_reg.rating) - 66'(do_train ? cl : pc))};
                        state_reg <= do_train ? S_UB1 : S_OUT;
                    end
                end
                S_UB1: state_reg <= S_UB2;
                S_UB2:
                begin
                    t1_reg <= bmf_pkg::sat32(66'(err_reg) - 66'(mp));
                    state_reg <= S_UB3;
                end
                S_UB3:
                begin
                    t2_reg <= bmf_pkg::sat32(66'(err_reg) - 66'(mp));
                    state_reg <= S_IB1;
                end
                S_IB1: state_reg <= S_IB2;
                S_IB2: state_reg <= cfg_reg.bias_only ? S_OUT : S_F_RD;
                S_F_RD: state_reg <= S_F_EQ;
                S_F_EQ:
                begin
                    p_reg <= uf_rd;
                    q_reg <= if_rd;
                    state_reg <= S_F_EP;
                end
                // t1 = e*q, t2 = e*p, then each minus its reg term
                S_F_EP:
                begin
                    t1_reg <= mp;
                    state_reg <= S_F_RP;
                end
                S_F_RP:
                begin
                    t2_reg <= mp;
                    state_reg <= S_F_RQ;
                end
                S_F_RQ:
                begin
                    t1_reg <= bmf_pkg::sat32(66'(t1_reg) - 66'(mp));
                    state_reg <= S_F_G1;
                end
                S_F_G1:
                begin
                    t2_reg <= bmf_pkg::sat32(66'(t2_reg) - 66'(mp));
                    state_reg <= S_F_G2;
                end
                S_F_G2:
                begin
                    np_reg <= bmf_pkg::sat32(66'(p_reg) + 66'(mp));
                    state_reg <= S_F_WR;
                end
                S_F_WR:
                begin
                    if (32'(k_reg) == FACTORS - 1)
                        state_reg <= S_OUT;
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                        state_reg <= S_F_RD;
                    end
                end
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: design/bmf_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bmf_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [63:0] out_data
);
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data), "out word dropped")
    `ASSERT_CLK(a_busy, clk, rst_n, out_valid |-> !in_ready, "accept while result pending")
    `ASSERT_NEXT(a_one, clk, rst_n, in_valid && in_ready, !in_ready, "second accept too soon")
endmodule

bind biased_mf_sgd_update_top bmf_checker u_chk (.clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data));

// File: tb/sv/biased_mf_sgd_update_top_tb.sv
`timescale 1ns / 1ps
module biased_mf_sgd_update_top_tb;

    localparam int NU = 1024;
    localparam int NI = 1024;
    localparam int NF = 16;
    localparam int FB = 16;
    localparam int SETTLE = 200;
    localparam int STALL_LEN = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    bmf_pkg::in_word_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    bmf_pkg::out_word_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    biased_mf_sgd_update_top DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow state of the engine
    logic signed [31:0] ubias [NU];
    logic signed [31:0] ibias [NI];
    logic signed [31:0] ufac [NU*NF];
    logic signed [31:0] ifac [NI*NF];
    bit uwritten [NU];
    bit iwritten [NI];
    logic [16:0] m_lr;
    logic [16:0] m_rw;
    logic signed [31:0] m_mean;
    logic signed [31:0] m_min;
    logic signed [31:0] m_max;
    logic m_bo;

    bmf_pkg::in_word_t pending_words [$];
    bmf_pkg::out_word_t scores_due [$];
    int in_idle_pct = 0;
    int out_idle_pct = 0;
    bit hold_out = 1'b0;
    int stall_cnt = 0;
    bit stall_req = 1'b0;
    int mismatches = 0;
    int n_scored = 0;
    int n_trained = 0;
    int n_cfg = 0;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic logic signed [31:0] clip32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) return 32'sh7fffffff;
        if (v < -66'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // arithmetic shift of a signed value is floor division
    function automatic logic signed [65:0] qshift(input logic signed [65:0] x);
        return x >>> FB;
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [65:0] x,
                                                 input logic signed [65:0] y);
        return clip32(qshift(x * y));
    endfunction

    function automatic logic signed [31:0] sgd_move(input logic signed [31:0] w,
                                                     input logic signed [31:0] grad);
        logic signed [31:0] g;
        g = clip32(66'(grad) - 66'(qmul(66'(m_rw), 66'(w))));
        return clip32(66'(w) + 66'(qmul(66'(m_lr), 66'(g))));
    endfunction

    function automatic bmf_pkg::out_word_t rate_item(input bmf_pkg::in_word_t w);
        bmf_pkg::out_word_t r;
        logic signed [65:0] acc;
        logic signed [31:0] pred;
        logic signed [31:0] err;
        logic signed [31:0] p;
        logic signed [31:0] q;
        int ub;
        int ib;
        r = '0;
        ub = int'(w.user_id) * NF;
        ib = int'(w.item_id) * NF;
        if (w.kind == bmf_pkg::KIND_WR_U) begin
            ufac[ub + w.factor_index] = w.factor_value;
        end else if (w.kind == bmf_pkg::KIND_WR_I) begin
            ifac[ib + w.factor_index] = w.factor_value;
        end else begin
            acc = 66'(m_mean) + 66'(ubias[w.user_id]) + 66'(ibias[w.item_id]);
            if (w.kind == bmf_pkg::KIND_EVAL || !m_bo)
                for (int k = 0; k < NF; k++)
                    acc += qshift(66'(ufac[ub + k]) * 66'(ifac[ib + k]));
            pred = clip32(acc);
            if (w.kind == bmf_pkg::KIND_TRAIN) begin
                if (pred > m_max) pred = m_max;
                if (pred < m_min) pred = m_min;
            end
            err = clip32(66'(w.rating) - 66'(pred));
            if (w.kind == bmf_pkg::KIND_TRAIN) begin
                ubias[w.user_id] = sgd_move(ubias[w.user_id], err);
                ibias[w.item_id] = sgd_move(ibias[w.item_id], err);
                if (!m_bo)
                    for (int k = 0; k < NF; k++) begin
                        p = ufac[ub + k];
                        q = ifac[ib + k];
                        ufac[ub + k] = sgd_move(p, qmul(66'(err), 66'(q)));
                        ifac[ib + k] = sgd_move(q, qmul(66'(err), 66'(p)));
                    end
            end
            r.prediction = pred;
            r.error = err;
        end
        return r;
    endfunction

    // driver
    always @(posedge clk) begin
        if (in_valid && in_ready) begin
            scores_due.push_back(rate_item(in_data));
            if (in_data.kind == bmf_pkg::KIND_TRAIN) n_trained++;
        end
        if (!in_valid || in_ready) begin
            if (pending_words.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
                in_data <= pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall counter
    always @(posedge clk) begin
        if (stall_req && stall_cnt == 0) begin
            stall_cnt <= STALL_LEN;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
        end
        if (stall_req && stall_cnt == 1) stall_req <= 1'b0;
    end

    // monitor
    always @(posedge clk) begin
        bmf_pkg::out_word_t exp_w;
        if (out_valid && out_ready) begin
            n_scored++;
            if (scores_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word %h", out_data);
            end else begin
                exp_w = scores_due.pop_front();
                if (out_data.prediction !== exp_w.prediction
                        || out_data.error !== exp_w.error) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pred exp %0d got %0d, err exp %0d got %0d",
                                 exp_w.prediction, out_data.prediction,
                                 exp_w.error, out_data.error);
                end
            end
        end
        out_ready <= !(stall_req || stall_cnt > 0) && ($urandom_range(99) >= out_idle_pct);
    end

    function automatic bmf_pkg::in_word_t mk(input logic [1:0] kind, input logic [9:0] u,
                                             input logic [9:0] i, input logic [31:0] rating,
                                             input logic [3:0] fi, input logic [31:0] fv);
        bmf_pkg::in_word_t w;
        w.kind = kind;
        w.user_id = u;
        w.item_id = i;
        w.rating = rating;
        w.factor_index = fi;
        w.factor_value = fv;
        return w;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            bmf_pkg::REG_LR: m_lr = val[16:0];
            bmf_pkg::REG_RW: m_rw = val[16:0];
            bmf_pkg::REG_MEAN: m_mean = val;
            bmf_pkg::REG_MIN: m_min = val;
            bmf_pkg::REG_MAX: m_max = val;
            bmf_pkg::REG_BO: m_bo = val[0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || in_valid || scores_due.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // load full factor rows so no unwritten entry is ever read
    task automatic load_rows(input logic [9:0] u, input logic [9:0] i, input int mag);
        for (int k = 0; k < NF; k++) begin
            pending_words.push_back(mk(bmf_pkg::KIND_WR_U, u, 10'($urandom), $urandom,
                k[3:0], 32'($signed($urandom_range(2 * mag)) - mag)));
            pending_words.push_back(mk(bmf_pkg::KIND_WR_I, 10'($urandom), i, $urandom,
                k[3:0], 32'($signed($urandom_range(2 * mag)) - mag)));
        end
        uwritten[u] = 1'b1;
        iwritten[i] = 1'b1;
    endtask

    function automatic logic [9:0] pick_user();
        logic [9:0] u;
        do u = 10'($urandom_range(15)); while (!uwritten[u]);
        return u;
    endfunction

    function automatic logic [9:0] pick_item();
        logic [9:0] i;
        do i = 10'($urandom_range(15)); while (!iwritten[i]);
        return i;
    endfunction

    task automatic random_phase(input int n);
        bmf_pkg::in_word_t w;
        for (int j = 0; j < n; j++) begin
            case ($urandom_range(9))
                0, 1: begin
                    w = mk(bmf_pkg::KIND_WR_U, pick_user(), 10'($urandom), $urandom,
                           4'($urandom),
                           ($urandom_range(9) == 0) ? $urandom
                               : 32'($signed($urandom_range(262144)) - 131072));
                end
                2: begin
                    w = mk(bmf_pkg::KIND_WR_I, 10'($urandom), pick_item(), $urandom,
                           4'($urandom),
                           ($urandom_range(9) == 0) ? $urandom
                               : 32'($signed($urandom_range(262144)) - 131072));
                end
                3: w = mk(bmf_pkg::KIND_EVAL, pick_user(), pick_item(), $urandom,
                          4'($urandom), $urandom);
                default: w = mk(bmf_pkg::KIND_TRAIN, pick_user(), pick_item(),
                                ($urandom_range(7) == 0) ? $urandom
                                    : 32'($urandom_range(393216)), 4'($urandom), $urandom);
            endcase
            pending_words.push_back(w);
        end
    endtask

    initial begin
        for (int k = 0; k < NU; k++) begin ubias[k] = '0; uwritten[k] = 1'b0; end
        for (int k = 0; k < NI; k++) begin ibias[k] = '0; iwritten[k] = 1'b0; end
        for (int k = 0; k < NU*NF; k++) ufac[k] = '0;
        for (int k = 0; k < NI*NF; k++) ifac[k] = '0;
        m_lr = 17'd655; m_rw = 17'd655; m_mean = '0; m_min = '0;
        m_max = 32'sd327680; m_bo = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme rows, large factors, saturation, evaluate
        in_idle_pct = 36; out_idle_pct = 67;
        load_rows(10'd0, 10'd1023, 65536);
        load_rows(10'd1023, 10'd0, 2147483647 / 2);
        for (int k = 0; k < 4; k++) load_rows(k[9:0], k[9:0], 131072);
        pending_words.push_back(mk(bmf_pkg::KIND_TRAIN, 10'd0, 10'd1023, 32'sh7fffffff,
                                   4'd0, 32'd0));
        pending_words.push_back(mk(bmf_pkg::KIND_TRAIN, 10'd0, 10'd1023, 32'sh80000000,
                                   4'd0, 32'd0));
        pending_words.push_back(mk(bmf_pkg::KIND_EVAL, 10'd1023, 10'd0, 32'sh80000000,
                                   4'd15, 32'hffffffff));
        pending_words.push_back(mk(bmf_pkg::KIND_TRAIN, 10'd1023, 10'd0, 32'sh7fffffff,
                                   4'd15, 32'd0));
        pending_words.push_back(mk(bmf_pkg::KIND_EVAL, 10'd0, 10'd1023, 32'h0, 4'd0, 32'd0));
        pending_words.push_back(mk(bmf_pkg::KIND_TRAIN, 10'd3, 10'd3, 32'sd196608,
                                   4'd0, 32'd0));
        drain();

        // crossed clamp limits, extreme rates, bias-only
        write_reg(bmf_pkg::REG_LR, 32'd65536);
        write_reg(bmf_pkg::REG_RW, 32'd65536);
        write_reg(bmf_pkg::REG_MEAN, 32'sh7fffffff);
        write_reg(bmf_pkg::REG_MIN, 32'sd300000);
        write_reg(bmf_pkg::REG_MAX, 32'sd100000);
        write_reg(bmf_pkg::REG_BO, 32'd1);
        in_idle_pct = 36; out_idle_pct = 67;
        random_phase(40);
        drain();

        write_reg(bmf_pkg::REG_LR, 32'd0);
        write_reg(bmf_pkg::REG_RW, 32'd0);
        write_reg(bmf_pkg::REG_MEAN, 32'sh80000000);
        write_reg(bmf_pkg::REG_MIN, 32'sh80000000);
        write_reg(bmf_pkg::REG_MAX, 32'sh7fffffff);
        write_reg(bmf_pkg::REG_BO, 32'd0);
        in_idle_pct = 67; out_idle_pct = 36;
        random_phase(60);
        drain();

        write_reg(bmf_pkg::REG_LR, 32'd6553);
        write_reg(bmf_pkg::REG_RW, 32'd1310);
        write_reg(bmf_pkg::REG_MEAN, 32'sd229376);
        write_reg(bmf_pkg::REG_MIN, 32'sd65536);
        write_reg(bmf_pkg::REG_MAX, 32'sd327680);
        in_idle_pct = 0; out_idle_pct = 0;
        // long receiver hold-off while words keep coming
        stall_req = 1'b1;
        random_phase(100);
        drain();

        write_reg(bmf_pkg::REG_BO, 32'd1);
        write_reg(bmf_pkg::REG_LR, 32'd655);
        random_phase(50);
        drain();

        $display("%0d words scored (%0d training), %0d register writes,",
                 n_scored, n_trained, n_cfg);
        $display("covering clamp, saturation, bias-only and backpressure cases");
        if (mismatches == 0 && scores_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end
endmodule
